// ----- sv/btmx_pkg.sv -----
// Package for the binary trie max-xor block: opcodes and sequencer state codes.
// No dependencies; used by binary_trie_max_xor.
package btmx_pkg;

    // Opcodes of an input word
    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_SEARCH = 2'd1;
    localparam logic [1:0] OP_MAXXOR = 2'd2;

    // Sequencer states
    localparam int unsigned ST_W = 2;
    localparam logic [ST_W-1:0] ST_IDLE   = 2'd0;
    localparam logic [ST_W-1:0] ST_WALK   = 2'd1;
    localparam logic [ST_W-1:0] ST_FINISH = 2'd2;

endpackage

// ----- sv/btmx_node_mem.sv -----
// Node store of the trie: one write port, one read port with registered data.
// No dependencies; instantiated by binary_trie_max_xor.
module btmx_node_mem #(
    parameter int unsigned DEPTH = 4096,
    parameter int unsigned AW    = 12,
    parameter int unsigned DW    = 24
) (
    input  logic          aclk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [DW-1:0] wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [DW-1:0] rd_data
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port, registered: data appears in the cycle after rd_en
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- sv/binary_trie_max_xor.sv -----
// Top level of the binary trie max-xor block: sequencer, root node, result register.
// Depends on btmx_pkg and btmx_node_mem.

// Binary trie of KEY_BITS levels over a store of NODE_COUNT nodes. Each input word
// (opcode, key) gives one result word. Insert, search and max-xor walk the key from
// its top bit down, one trie level per cycle: the next node's links come from the
// node store's registered read port in the cycle after its address is issued, or are
// known to be null when the node was just allocated. An item is accepted in the idle
// state, walks the levels in the walk state and loads the result register in the
// finish state; a search ends at the first missing node, and a refused insert, a
// max-xor on an empty trie and an unknown opcode skip the walk and go straight to the
// finish state. A new word is taken as soon as the sequencer is idle, also while
// the previous result still waits on m_ready; a finished walk holds until the result
// register is free. The root's links live in flip-flops that reset clears; every
// other node that is ever read is written first, when its child is allocated, so the
// store needs no clearing pass after reset.
module binary_trie_max_xor #(
    parameter int unsigned KEY_BITS   = 32,
    parameter int unsigned NODE_COUNT = 4096
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_opcode,
    input  logic [31:0] s_key,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_found,
    output logic [31:0] m_best_xor,
    output logic        m_empty_res,
    output logic        m_refused
);

    localparam int unsigned NW = $clog2(NODE_COUNT);
    localparam int unsigned EW = 2 * NW;
    localparam int unsigned LW = (KEY_BITS > 1) ? $clog2(KEY_BITS) : 1;
    localparam logic [NW:0] NODE_LIMIT = (NW+1)'(NODE_COUNT);
    localparam logic [NW:0] FREE_LIMIT = (NW+1)'(NODE_COUNT - KEY_BITS);

    // Control state
    logic [btmx_pkg::ST_W-1:0] state_reg, state_next;
    logic [NW:0]               nfn_reg, nfn_next;
    logic                      has_entries_reg, has_entries_next;
    logic [EW-1:0]             root_reg, root_next;
    logic                      m_valid_reg, m_valid_next;

    // Walk state
    logic [1:0]          op_reg, op_next;
    logic [KEY_BITS-1:0] key_reg, key_next;
    logic [KEY_BITS-1:0] best_reg, best_next;
    logic [LW-1:0]       level_reg, level_next;
    logic [NW-1:0]       node_reg, node_next;
    logic [EW-1:0]       ent_reg, ent_next;
    logic                from_mem_reg, from_mem_next;
    logic                found_reg, found_next;
    logic                empty_reg, empty_next;
    logic                refused_reg, refused_next;

    // Result register
    logic        m_found_reg, m_empty_reg, m_refused_reg;
    logic [31:0] m_best_reg;

    // Node store ports
    logic          mem_we, mem_re;
    logic [NW-1:0] mem_waddr, mem_raddr;
    logic [EW-1:0] mem_wdata, mem_rdata;

    // Current level decode
    logic [EW-1:0] cur_ent;
    logic          kbit;
    logic [NW-1:0] link_same, link_opp, child;
    logic          null_same, null_opp, null_child;
    logic          last_level, out_free;

    btmx_node_mem #(
        .DEPTH (NODE_COUNT),
        .AW    (NW),
        .DW    (EW)
    ) u_node_mem (
        .aclk    (aclk),
        .wr_en   (mem_we),
        .wr_addr (mem_waddr),
        .wr_data (mem_wdata),
        .rd_en   (mem_re),
        .rd_addr (mem_raddr),
        .rd_data (mem_rdata)
    );

    // Links of the node at this level; out-of-range links count as null
    assign cur_ent    = from_mem_reg ? mem_rdata : ent_reg;
    assign kbit       = key_reg[KEY_BITS-1];
    assign link_same  = kbit ? cur_ent[EW-1:NW] : cur_ent[NW-1:0];
    assign link_opp   = kbit ? cur_ent[NW-1:0] : cur_ent[EW-1:NW];
    assign null_same  = (link_same == '0) || ({1'b0, link_same} >= NODE_LIMIT);
    assign null_opp   = (link_opp == '0) || ({1'b0, link_opp} >= NODE_LIMIT);
    assign last_level = (level_reg == '0);
    assign out_free   = !m_valid_reg || m_ready;

    assign s_ready = (state_reg == btmx_pkg::ST_IDLE);

    // Max-xor follows the opposite branch where it exists
    always_comb begin
        if (op_reg == btmx_pkg::OP_MAXXOR && !null_opp) begin
            child      = link_opp;
            null_child = 1'b0;
        end else begin
            child      = link_same;
            null_child = null_same;
        end
    end

    // Sequencer
    always_comb begin
        state_next       = state_reg;
        nfn_next         = nfn_reg;
        has_entries_next = has_entries_reg;
        root_next        = root_reg;
        op_next          = op_reg;
        key_next         = key_reg;
        best_next        = best_reg;
        level_next       = level_reg;
        node_next        = node_reg;
        ent_next         = ent_reg;
        from_mem_next    = from_mem_reg;
        found_next       = found_reg;
        empty_next       = empty_reg;
        refused_next     = refused_reg;
        mem_we           = 1'b0;
        mem_waddr        = node_reg;
        mem_wdata        = cur_ent;
        mem_re           = 1'b0;
        mem_raddr        = child;

        case (state_reg)
            btmx_pkg::ST_IDLE: begin
                if (s_valid) begin
                    op_next       = s_opcode;
                    key_next      = KEY_BITS'(s_key);
                    best_next     = '0;
                    level_next    = LW'(KEY_BITS - 1);
                    node_next     = '0;
                    ent_next      = root_reg;
                    from_mem_next = 1'b0;
                    found_next    = 1'b0;
                    empty_next    = 1'b0;
                    refused_next  = 1'b0;
                    state_next    = btmx_pkg::ST_FINISH;
                    case (s_opcode)
                        btmx_pkg::OP_INSERT: begin
                            if (nfn_reg > FREE_LIMIT) begin
                                refused_next = 1'b1;
                            end else begin
                                has_entries_next = 1'b1;
                                state_next       = btmx_pkg::ST_WALK;
                            end
                        end
                        btmx_pkg::OP_SEARCH: begin
                            state_next = btmx_pkg::ST_WALK;
                        end
                        btmx_pkg::OP_MAXXOR: begin
                            if (!has_entries_reg) begin
                                empty_next = 1'b1;
                            end else begin
                                state_next = btmx_pkg::ST_WALK;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end

            btmx_pkg::ST_WALK: begin
                key_next   = KEY_BITS'({key_reg, 1'b0});
                level_next = level_reg - LW'(1);
                if (last_level) begin
                    state_next = btmx_pkg::ST_FINISH;
                end
                case (op_reg)
                    btmx_pkg::OP_INSERT: begin
                        if (null_same) begin
                            // Allocate: link the parent to the new node, whose links are null
                            mem_wdata = kbit ? {nfn_reg[NW-1:0], cur_ent[NW-1:0]}
                                             : {cur_ent[EW-1:NW], nfn_reg[NW-1:0]};
                            if (node_reg == '0) begin
                                root_next = mem_wdata;
                            end else begin
                                mem_we = 1'b1;
                            end
                            nfn_next      = nfn_reg + (NW+1)'(1);
                            node_next     = nfn_reg[NW-1:0];
                            ent_next      = '0;
                            from_mem_next = 1'b0;
                        end else begin
                            mem_re        = !last_level;
                            node_next     = link_same;
                            from_mem_next = 1'b1;
                        end
                    end
                    btmx_pkg::OP_SEARCH: begin
                        if (null_same) begin
                            state_next = btmx_pkg::ST_FINISH;
                        end else if (last_level) begin
                            found_next = 1'b1;
                        end else begin
                            mem_re        = 1'b1;
                            node_next     = link_same;
                            from_mem_next = 1'b1;
                        end
                    end
                    default: begin
                        // Max-xor; a dead end falls back to the root
                        best_next = KEY_BITS'({best_reg, !null_opp});
                        if (null_child) begin
                            node_next     = '0;
                            ent_next      = root_reg;
                            from_mem_next = 1'b0;
                        end else begin
                            mem_re        = !last_level;
                            node_next     = child;
                            from_mem_next = 1'b1;
                        end
                    end
                endcase
            end

            btmx_pkg::ST_FINISH: begin
                if (out_free) begin
                    state_next = btmx_pkg::ST_IDLE;
                end
            end

            default: begin
                state_next = btmx_pkg::ST_IDLE;
            end
        endcase
    end

    // Result word valid
    always_comb begin
        m_valid_next = m_valid_reg;
        if (m_ready) begin
            m_valid_next = 1'b0;
        end
        if (state_reg == btmx_pkg::ST_FINISH && out_free) begin
            m_valid_next = 1'b1;
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= btmx_pkg::ST_IDLE;
            nfn_reg         <= (NW+1)'(1);
            has_entries_reg <= 1'b0;
            root_reg        <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg       <= state_next;
            nfn_reg         <= nfn_next;
            has_entries_reg <= has_entries_next;
            root_reg        <= root_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    // Walk registers
    always_ff @(posedge aclk) begin
        op_reg       <= op_next;
        key_reg      <= key_next;
        best_reg     <= best_next;
        level_reg    <= level_next;
        node_reg     <= node_next;
        ent_reg      <= ent_next;
        from_mem_reg <= from_mem_next;
        found_reg    <= found_next;
        empty_reg    <= empty_next;
        refused_reg  <= refused_next;
    end

    // Result payload
    always_ff @(posedge aclk) begin
        if (state_reg == btmx_pkg::ST_FINISH && out_free) begin
            m_found_reg   <= found_reg;
            m_best_reg    <= 32'(best_reg);
            m_empty_reg   <= empty_reg;
            m_refused_reg <= refused_reg;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_found     = m_found_reg;
    assign m_best_xor  = m_best_reg;
    assign m_empty_res = m_empty_reg;
    assign m_refused   = m_refused_reg;

`ifndef NO_ASSERTIONS
    // The bump pointer never runs past the store
    a_nfn_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        nfn_reg <= NODE_LIMIT)
        else $error("node allocator ran past the store");

    // Reads and writes of the store never share a cycle
    a_mem_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(mem_we && mem_re))
        else $error("node store read and write in one cycle");

    // The root lives in flip-flops, never in the store
    a_no_root_write: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_we |-> (mem_waddr != '0))
        else $error("node store write to the root");

    // Once filled, the trie never becomes empty again
    a_entries_stay: assert property (@(posedge aclk) disable iff (!aresetn)
        has_entries_reg |=> has_entries_reg)
        else $error("trie lost its entries");
`endif

endmodule

// ----- bench/binary_trie_max_xor_checker.sv -----
// Checker for binary_trie_max_xor: watches both channels, keeps its own copy of the trie,
// predicts each result word and compares it field by field with what the block returns.
// Depends on btmx_pkg.
module binary_trie_max_xor_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [1:0]  s_opcode,
    input  logic [31:0] s_key,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic        m_found,
    input  logic [31:0] m_best_xor,
    input  logic        m_empty_res,
    input  logic        m_refused,
    output int          fail_count,
    output int          pending_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int KEY_BITS   = 32;
    localparam int NODE_COUNT = 4096;

    typedef struct packed {
        logic        found;
        logic [31:0] best_xor;
        logic        empty_res;
        logic        refused;
    } trie_answer_t;

    // Shadow trie: child pair per node, 0 is null since the root is nobody's child
    int unsigned  child_link [NODE_COUNT][2];
    int unsigned  next_free_node;
    bit           has_entries;
    trie_answer_t trie_answers [$];
    int           mismatch_count = 0;

    // Apply one input word to the shadow trie and return the answer it should give
    function automatic trie_answer_t walk_trie(logic [1:0] op, logic [31:0] key);
        trie_answer_t ans;
        int unsigned  node;
        int unsigned  nxt;
        int           lvl;
        logic         b;
        ans  = '0;
        node = 0;
        case (op)
            btmx_pkg::OP_INSERT: begin
                // refused while fewer than a full path of nodes is left, duplicates too
                if (NODE_COUNT - next_free_node < KEY_BITS) begin
                    ans.refused = 1'b1;
                end else begin
                    for (lvl = KEY_BITS - 1; lvl >= 0; lvl--) begin
                        b   = key[lvl];
                        nxt = child_link[node][b];
                        if (nxt == 0) begin
                            nxt = next_free_node;
                            next_free_node++;
                            child_link[nxt][0] = 0;
                            child_link[nxt][1] = 0;
                            child_link[node][b] = nxt;
                        end
                        node = nxt;
                    end
                    has_entries = 1'b1;
                end
            end
            btmx_pkg::OP_SEARCH: begin
                ans.found = 1'b1;
                for (lvl = KEY_BITS - 1; lvl >= 0 && ans.found; lvl--) begin
                    nxt = child_link[node][key[lvl]];
                    if (nxt == 0) begin
                        ans.found = 1'b0;
                    end
                    node = nxt;
                end
            end
            btmx_pkg::OP_MAXXOR: begin
                if (!has_entries) begin
                    ans.empty_res = 1'b1;
                end else begin
                    // greedy: opposite branch wherever it exists
                    for (lvl = KEY_BITS - 1; lvl >= 0; lvl--) begin
                        b   = key[lvl];
                        nxt = child_link[node][~b];
                        if (nxt != 0) begin
                            ans.best_xor[lvl] = 1'b1;
                            node = nxt;
                        end else begin
                            node = child_link[node][b];
                        end
                    end
                end
            end
            default: ;
        endcase
        return ans;
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            mismatch_count++;
        end
    endfunction

    // Results are compared before new words are predicted; a result never
    // belongs to a word taken at the same edge
    always @(posedge aclk) begin
        trie_answer_t want;
        if (!aresetn) begin
            trie_answers.delete();
            child_link[0][0] = 0;
            child_link[0][1] = 0;
            next_free_node   = 1;
            has_entries      = 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (trie_answers.size() == 0) begin
                    $display("%0t: result word with none expected, actual %b %h %b %b",
                             $time, m_found, m_best_xor, m_empty_res, m_refused);
                    mismatch_count++;
                end else begin
                    want = trie_answers.pop_front();
                    check_field("found", want.found, m_found);
                    check_field("best_xor", want.best_xor, m_best_xor);
                    check_field("empty_res", want.empty_res, m_empty_res);
                    check_field("refused", want.refused, m_refused);
                end
            end
            if (s_valid && s_ready) begin
                trie_answers.push_back(walk_trie(s_opcode, s_key));
            end
        end
        fail_count    <= mismatch_count;
        pending_count <= trie_answers.size();
    end

endmodule

// ----- bench/binary_trie_max_xor_tb.sv -----
// Top of the binary_trie_max_xor bench: clock, reset, input words and result back-pressure.
// Depends on btmx_pkg, binary_trie_max_xor and binary_trie_max_xor_checker.
module binary_trie_max_xor_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int PHASE_WORDS    = 460;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int DRAIN_CYCLES   = 40;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_valid  = 1'b0;
    logic [1:0]  s_opcode = btmx_pkg::OP_INSERT;
    logic [31:0] s_key    = '0;
    logic        m_ready  = 1'b0;
    logic        s_ready;
    logic        m_valid;
    logic        m_found;
    logic [31:0] m_best_xor;
    logic        m_empty_res;
    logic        m_refused;

    int          send_gap_pct   = 0;
    int          recv_stall_pct = 0;
    int          quiet_cycles   = 0;
    int          fail_count;
    int          pending_count;
    logic [31:0] key_bases [8];
    logic [31:0] known_keys [$];

    binary_trie_max_xor uut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_opcode    (s_opcode),
        .s_key       (s_key),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_found     (m_found),
        .m_best_xor  (m_best_xor),
        .m_empty_res (m_empty_res),
        .m_refused   (m_refused)
    );

    binary_trie_max_xor_checker trie_check (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_opcode      (s_opcode),
        .s_key         (s_key),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_found       (m_found),
        .m_best_xor    (m_best_xor),
        .m_empty_res   (m_empty_res),
        .m_refused     (m_refused),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Receiver back-pressure
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Watchdog on cycles with no word moving on either side
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("simulation failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Key sharing a prefix with one of a few bases, so paths overlap and the store
    // fills slowly
    function automatic logic [31:0] near_base();
        logic [31:0] mask;
        mask = (32'h1 << $urandom_range(12, 1)) - 32'h1;
        return (key_bases[$urandom_range(7)] & ~mask) | ($urandom & mask);
    endfunction

    function automatic logic [31:0] known_key();
        if (known_keys.size() == 0) begin
            return near_base();
        end
        return known_keys[$urandom_range(known_keys.size() - 1)];
    endfunction

    // Offer one word, with an optional gap first, and hold it until taken
    task automatic send_word(input logic [1:0] op, input logic [31:0] k);
        if ($urandom_range(99) < send_gap_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < send_gap_pct);
        end
        s_valid  <= 1'b1;
        s_opcode <= op;
        s_key    <= k;
        do @(posedge aclk); while (!(s_valid && s_ready));
        if (op == btmx_pkg::OP_INSERT) begin
            known_keys.push_back(k);
        end
    endtask

    initial begin
        int          choice;
        int          sel;
        int          phase;
        logic [31:0] k;
        logic [31:0] flip;
        foreach (key_bases[i]) begin
            key_bases[i] = $urandom;
        end
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: empty trie, unknown opcode, extreme keys, duplicates
        send_word(btmx_pkg::OP_MAXXOR, 32'h1234_5678);
        send_word(btmx_pkg::OP_SEARCH, 32'h0000_0000);
        send_word(OP_UNUSED, 32'h0000_0000);
        send_word(btmx_pkg::OP_INSERT, 32'h0000_0000);
        send_word(btmx_pkg::OP_SEARCH, 32'h0000_0000);
        send_word(btmx_pkg::OP_SEARCH, 32'hFFFF_FFFF);
        send_word(btmx_pkg::OP_MAXXOR, 32'h0000_0000);
        send_word(btmx_pkg::OP_MAXXOR, 32'hFFFF_FFFF);
        send_word(btmx_pkg::OP_INSERT, 32'hFFFF_FFFF);
        send_word(btmx_pkg::OP_MAXXOR, 32'h0000_0000);
        send_word(btmx_pkg::OP_SEARCH, 32'hFFFF_FFFF);
        send_word(btmx_pkg::OP_INSERT, 32'h0000_0000);
        send_word(btmx_pkg::OP_INSERT, 32'h8000_0000);
        send_word(btmx_pkg::OP_SEARCH, 32'h8000_0000);
        send_word(btmx_pkg::OP_SEARCH, 32'h8000_0001);
        send_word(btmx_pkg::OP_MAXXOR, 32'h7FFF_FFFF);
        send_word(OP_UNUSED, 32'hFFFF_FFFF);
        send_word(btmx_pkg::OP_INSERT, 32'h0000_0001);
        send_word(btmx_pkg::OP_MAXXOR, 32'h0000_0001);
        send_word(btmx_pkg::OP_SEARCH, 32'h0000_0001);

        // Random: sender 20 / receiver 75, then swapped, then no idling
        for (phase = 0; phase < 3; phase++) begin
            send_gap_pct   <= (phase == 0) ? 20 : (phase == 1) ? 75 : 0;
            recv_stall_pct <= (phase == 0) ? 75 : (phase == 1) ? 20 : 0;
            repeat (PHASE_WORDS) begin
                choice = $urandom_range(99);
                sel    = $urandom_range(9);
                flip   = 32'h1 << $urandom_range(31);
                if (choice < 5) begin
                    send_word(OP_UNUSED, $urandom);
                end else if (choice < 45) begin
                    // about one insert in five takes a fresh random path
                    k = ($urandom_range(4) == 0) ? $urandom : near_base();
                    send_word(btmx_pkg::OP_INSERT, k);
                end else if (choice < 70) begin
                    k = (sel < 6) ? known_key() : (sel < 8) ? known_key() ^ flip : near_base();
                    send_word(btmx_pkg::OP_SEARCH, k);
                end else begin
                    k = (sel < 4) ? $urandom : (sel < 7) ? near_base() : known_key() ^ flip;
                    send_word(btmx_pkg::OP_MAXXOR, k);
                end
            end
        end
        s_valid <= 1'b0;

        do @(posedge aclk); while (pending_count != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// ----- files.f -----
sv/btmx_pkg.sv
sv/btmx_node_mem.sv
sv/binary_trie_max_xor.sv
bench/binary_trie_max_xor_checker.sv
bench/binary_trie_max_xor_tb.sv
